// ===== hdl/gfe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfe_pkg
// Shared types and constants of the forward elimination block.
// ----------------------------------------------------------------------------
package gfe_pkg;
  localparam int unsigned DataW = 32;
  localparam int unsigned SizeW = 4;
  localparam int unsigned FracW = 16;
  localparam logic [SizeW-1:0] SizeReset = 4'd3;
  localparam logic signed [DataW-1:0] SatMax = 32'sh7fffffff;
  localparam logic signed [DataW-1:0] SatMin = 32'sh80000000;

  typedef logic signed [DataW-1:0] data_t;

  // saturate a wide signed value to 32 bits
  function automatic data_t sat64(input logic signed [65:0] v);
    if (v > 66'sd2147483647) begin
      return SatMax;
    end else if (v < -66'sd2147483648) begin
      return SatMin;
    end
    return v[DataW-1:0];
  endfunction
endpackage

// ===== hdl/gfe_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfe_div
// Bit-serial signed divider: trunc(num * 2^16 / den), saturated to 32 bits.
// ----------------------------------------------------------------------------
module gfe_div (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  gfe_pkg::data_t       num_i,
  input  gfe_pkg::data_t       den_i,
  output logic                 done_o,
  output gfe_pkg::data_t       quot_o
);
  logic [47:0] rem_q, rem_d;
  logic [47:0] dvd_q, dvd_d;
  logic [31:0] dsr_q;
  logic [47:0] quo_q, quo_d;
  logic [5:0]  cnt_q;
  logic        busy_q, neg_q;
  logic [48:0] trial;
  logic [47:0] num_mag;
  logic [31:0] den_mag;
  logic signed [49:0] sq;

  assign num_mag = {(num_i[31] ? 32'(-num_i) : 32'(num_i)), 16'd0};
  assign den_mag = den_i[31] ? 32'(-den_i) : 32'(den_i);
  assign trial = {rem_q, dvd_q[47]} - {17'd0, dsr_q};

  always_comb begin
    rem_d = {rem_q[46:0], dvd_q[47]};
    quo_d = {quo_q[46:0], 1'b0};
    dvd_d = {dvd_q[46:0], 1'b0};
    if (!trial[48]) begin
      rem_d = trial[47:0];
      quo_d[0] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'd47;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      dvd_q <= num_mag;
      dsr_q <= den_mag;
      quo_q <= '0;
      neg_q <= num_i[31] ^ den_i[31];
    end else if (busy_q) begin
      rem_q <= rem_d;
      dvd_q <= dvd_d;
      quo_q <= quo_d;
    end
  end

  assign sq = neg_q ? -$signed({2'b0, quo_q}) : $signed({2'b0, quo_q});
  assign quot_o = gfe_pkg::sat64(66'(sq));
endmodule

// ===== hdl/gaussian_forward_elimination.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_forward_elimination
// Fixed-point forward elimination with partial pivoting on a stored matrix.
// ----------------------------------------------------------------------------
// Usage: write matrix_size through cfg_we_i/cfg_wdata_i while idle (any write
// drops a partial load). Present one Q16.16 element on element_value_i with
// start_i; it transfers at an edge where busy_o is low. Elements may be
// loaded back to back. After the n*n-th element busy_o rises and the block
// reduces the matrix held in one synchronous single-port memory: per column
// a pivot search (read and compare per row), a row swap if another row holds
// the largest pivot magnitude, then for a nonzero pivot one serial division
// per row below and a read, multiply, subtract and write back through the
// memory port per updated element. The reduced matrix then streams out in
// row-major order, each element shown for one cycle with result_valid_o;
// last_element_o marks the final one and singular_flag_o is set on every
// element if a column had no nonzero pivot. The receiver cannot stall.
// Reset leaves the size at 3 and the load count at zero; memory is not cleared.
// ----------------------------------------------------------------------------
module gaussian_forward_elimination #(
  parameter int unsigned MAX_SIZE = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gfe_pkg::SizeW-1:0]   cfg_wdata_i,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic signed [31:0]          element_value_i,
  output logic                        result_valid_o,
  output logic signed [31:0]          result_value_o,
  output logic                        last_element_o,
  output logic                        singular_flag_o
);
  localparam int unsigned Cells = MAX_SIZE * MAX_SIZE;
  localparam int unsigned AW = $clog2(Cells);
  localparam int unsigned IW = $clog2(MAX_SIZE + 1);

  localparam logic [4:0] S_LOAD = 5'd0, S_PV_RD = 5'd1, S_PV_CMP = 5'd2,
    S_PV_END = 5'd3, S_SW_RA = 5'd4, S_SW_RB = 5'd5, S_SW_WA = 5'd6,
    S_SW_WB = 5'd7, S_F_RP = 5'd8, S_F_RA = 5'd9, S_F_DIV = 5'd10,
    S_F_WAIT = 5'd11, S_U_RP = 5'd12, S_U_RA = 5'd13, S_U_MUL = 5'd14,
    S_U_WR = 5'd15, S_Z_WR = 5'd16, S_OUT_RD = 5'd17, S_OUT_EM = 5'd18,
    S_F_LD = 5'd19;

  gfe_pkg::data_t mem [Cells];
  gfe_pkg::data_t rd_q, piv_q, tmp_q, fac_q, quot;
  logic signed [63:0] prod_q;
  logic [AW-1:0] addr;
  logic we;
  gfe_pkg::data_t wd;
  logic [4:0] st_q;
  logic [gfe_pkg::SizeW-1:0] size_q;
  logic [IW-1:0] n, j_q, i_q, k_q, best_q;
  logic [AW:0] cnt_q;
  logic [AW:0] total;
  logic [32:0] bmag_q, mag;
  logic sing_q, div_go, div_done;
  logic signed [65:0] diff;
  logic signed [63:0] fl;

  always_comb begin
    if (size_q == '0) n = IW'(1);
    else if (32'(size_q) > MAX_SIZE) n = IW'(MAX_SIZE);
    else n = IW'(size_q);
  end
  assign total = (AW+1)'(n) * (AW+1)'(n);

  function automatic logic [AW-1:0] ix(input logic [IW-1:0] r, input logic [IW-1:0] c,
                                       input logic [IW-1:0] nn);
    return AW'(r) * AW'(nn) + AW'(c);
  endfunction

  assign mag = rd_q[31] ? 33'(-$signed({rd_q[31], rd_q})) : {1'b0, rd_q};
  assign fl = prod_q >>> gfe_pkg::FracW;
  assign diff = 66'(rd_q) - 66'(fl);

  gfe_div u_div (.clk_i, .rst_ni, .start_i(div_go), .num_i(rd_q), .den_i(piv_q),
                 .done_o(div_done), .quot_o(quot));

  // address, write and divider launch per state
  always_comb begin
    addr = '0; we = 1'b0; wd = rd_q; div_go = 1'b0;
    unique case (st_q)
      S_LOAD:   begin addr = cnt_q[AW-1:0]; we = start_i; wd = element_value_i; end
      S_PV_RD:  addr = ix(i_q, j_q, n);
      S_SW_RA:  addr = ix(j_q, k_q, n);
      S_SW_RB:  addr = ix(best_q, k_q, n);
      S_SW_WA:  begin addr = ix(j_q, k_q, n); we = 1'b1; wd = rd_q; end
      S_SW_WB:  begin addr = ix(best_q, k_q, n); we = 1'b1; wd = tmp_q; end
      S_F_RP:   addr = ix(j_q, j_q, n);
      S_F_RA:   addr = ix(i_q, j_q, n);
      S_F_DIV:  div_go = 1'b1;
      S_U_RP:   addr = ix(j_q, k_q, n);
      S_U_RA:   addr = ix(i_q, k_q, n);
      // hold the row element on the read port for the write-back cycle
      S_U_MUL:  addr = ix(i_q, k_q, n);
      S_U_WR:   begin addr = ix(i_q, k_q, n); we = 1'b1; wd = gfe_pkg::sat64(diff); end
      S_Z_WR:   begin addr = ix(i_q, j_q, n); we = 1'b1; wd = '0; end
      S_OUT_RD: addr = cnt_q[AW-1:0];
      default:  addr = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) mem[addr] <= wd;
    rd_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_LOAD; size_q <= gfe_pkg::SizeReset; cnt_q <= '0; sing_q <= 1'b0;
      j_q <= '0; i_q <= '0; k_q <= '0; best_q <= '0; bmag_q <= '0;
      result_valid_o <= 1'b0; last_element_o <= 1'b0;
    end else begin
      result_valid_o <= 1'b0;
      last_element_o <= 1'b0;
      unique case (st_q)
        S_LOAD: begin
          if (cfg_we_i) begin
            size_q <= cfg_wdata_i; cnt_q <= '0;
          end else if (start_i) begin
            // start reduction once the last element transfers
            if (cnt_q + 1'b1 == total) begin
              cnt_q <= '0; sing_q <= 1'b0; j_q <= '0; i_q <= '0;
              best_q <= '0; bmag_q <= '0; st_q <= S_PV_RD;
            end else cnt_q <= cnt_q + 1'b1;
          end
        end
        S_PV_RD: st_q <= S_PV_CMP;
        S_PV_CMP: begin
          if (mag > bmag_q) begin bmag_q <= mag; best_q <= i_q; end
          if (i_q + 1'b1 == n) st_q <= S_PV_END;
          else begin i_q <= i_q + 1'b1; st_q <= S_PV_RD; end
        end
        S_PV_END: begin
          k_q <= '0; i_q <= j_q + 1'b1;
          if (bmag_q == '0) begin
            sing_q <= 1'b1; st_q <= S_F_LD;
          end else if (best_q != j_q) st_q <= S_SW_RA;
          else st_q <= S_F_LD;
        end
        S_SW_RA: st_q <= S_SW_RB;
        S_SW_RB: begin tmp_q <= rd_q; st_q <= S_SW_WA; end
        S_SW_WA: st_q <= S_SW_WB;
        S_SW_WB: begin
          if (k_q + 1'b1 == n) st_q <= S_F_LD;
          else begin k_q <= k_q + 1'b1; st_q <= S_SW_RA; end
        end
        S_F_LD: begin
          // next row below pivot, or next column
          if (bmag_q == '0 || i_q >= n) begin
            if (j_q + 1'b1 >= n) begin cnt_q <= '0; st_q <= S_OUT_RD; end
            else begin
              j_q <= j_q + 1'b1; i_q <= j_q + 1'b1; best_q <= j_q + 1'b1;
              bmag_q <= '0; st_q <= S_PV_RD;
            end
          end else st_q <= S_F_RP;
        end
        S_F_RP: st_q <= S_F_RA;
        S_F_RA: begin piv_q <= rd_q; st_q <= S_F_DIV; end
        S_F_DIV: st_q <= S_F_WAIT;
        S_F_WAIT: if (div_done) begin
          fac_q <= quot; k_q <= j_q + 1'b1;
          st_q <= (j_q + 1'b1 >= n) ? S_Z_WR : S_U_RP;
        end
        S_U_RP: st_q <= S_U_RA;
        S_U_RA: begin prod_q <= 64'(fac_q) * 64'(rd_q); st_q <= S_U_MUL; end
        S_U_MUL: st_q <= S_U_WR;
        S_U_WR: begin
          if (k_q + 1'b1 >= n) st_q <= S_Z_WR;
          else begin k_q <= k_q + 1'b1; st_q <= S_U_RP; end
        end
        S_Z_WR: begin i_q <= i_q + 1'b1; st_q <= S_F_LD; end
        S_OUT_RD: st_q <= S_OUT_EM;
        S_OUT_EM: begin
          result_valid_o <= 1'b1;
          last_element_o <= (cnt_q + 1'b1 == total);
          if (cnt_q + 1'b1 == total) begin cnt_q <= '0; st_q <= S_LOAD; end
          else begin cnt_q <= cnt_q + 1'b1; st_q <= S_OUT_RD; end
        end
        default: st_q <= S_LOAD;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == S_OUT_EM) result_value_o <= rd_q;
  end

  assign busy_o = (st_q != S_LOAD);
  assign singular_flag_o = sing_q;

`ifndef NO_ASSERTIONS
  a_no_out_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(st_q) == S_OUT_EM) else $error("stray result");
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && last_element_o) |-> !busy_o) else $error("last not final");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_element_o |-> result_valid_o) else $error("last without result");
`endif
endmodule
